// File: sv/svgm_pkg.sv
// ----------------------------------------------------------------------------
// svgm_pkg
// Shared types and constants for the state vector gate and measure engine.
// ----------------------------------------------------------------------------
`default_nettype none

package svgm_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int ADDR_W     = MAX_QUBITS;
  localparam int DEPTH      = 1 << MAX_QUBITS;
  localparam int CNT_W      = ADDR_W + 1;
  localparam int AMP_W      = 16;
  localparam int FRAC_W     = 14;
  localparam int DATA_W     = 2 * AMP_W;
  localparam int QB_W       = 4;
  localparam int SUM_W      = 2 * AMP_W + 2;
  localparam int SQ_W       = 2 * AMP_W;
  localparam int PROB_W     = SQ_W + MAX_QUBITS;
  localparam int RND_W      = 16;
  localparam int CMPV_W     = PROB_W + RND_W;
  localparam int SQRT_W     = 60;
  localparam int ROOT_W     = 30;
  localparam int QUOT_W     = 16;
  localparam int NUM_W      = ROOT_W + QUOT_W;
  localparam int SQRT_STEPS = 30;
  localparam int RN_SHIFT   = 22;

  localparam logic signed [AMP_W-1:0] AMP_ONE = AMP_W'(1 << FRAC_W);

  typedef enum logic [1:0] {
    CMD_RESET   = 2'd0,
    CMD_GATE    = 2'd1,
    CMD_MEASURE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_ZERO  = 2'd2;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_FIN, ST_RD,
    ST_G_RA, ST_G_RB, ST_G_CAP, ST_G_MUL, ST_G_SUM, ST_G_WA, ST_G_WB,
    ST_M_SUM, ST_M_DRN, ST_M_TOT, ST_M_MUL, ST_M_CMP, ST_M_SQRT, ST_M_LIM,
    ST_M_RD, ST_M_LAT, ST_M_CHK, ST_M_DIV, ST_M_WR
  } state_e;

endpackage

`default_nettype wire

// File: sv/state_vector_gate_measure.sv
// ----------------------------------------------------------------------------
// state_vector_gate_measure
// Single-qubit gate and measurement engine over a 2^n amplitude state vector.
// ----------------------------------------------------------------------------
// One command at a time: start is taken when busy is low, and every command
// gives one result on done_o for one cycle; the receiver cannot stall it.
// All amplitudes live in one 1024 x 32 RAM. After reset the RAM is cleared
// in one pass over all entries (busy high); CMD_RESET runs the same pass.
// A gate walks 2^(n-1) pairs through the RAM's one read and one write port.
// A measure runs a probability pass over the 2^n amplitudes and a square
// root, then renormalizes amplitude by amplitude, bound by the bit-serial
// dividers. Range errors go straight to the finish step.
// ----------------------------------------------------------------------------
`default_nettype none

module state_vector_gate_measure
  import svgm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              cmd_i,
  input  wire logic [QB_W-1:0]         target_qubit_i,
  input  wire logic signed [AMP_W-1:0] g00_re_i,
  input  wire logic signed [AMP_W-1:0] g00_im_i,
  input  wire logic signed [AMP_W-1:0] g01_re_i,
  input  wire logic signed [AMP_W-1:0] g01_im_i,
  input  wire logic signed [AMP_W-1:0] g10_re_i,
  input  wire logic signed [AMP_W-1:0] g10_im_i,
  input  wire logic signed [AMP_W-1:0] g11_re_i,
  input  wire logic signed [AMP_W-1:0] g11_im_i,
  input  wire logic [RND_W-1:0]        random_fraction_i,
  input  wire logic [ADDR_W-1:0]       amp_index_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [QB_W-1:0]         cfg_data_i,
  output logic                         done_o,
  output logic                         outcome_o,
  output logic signed [AMP_W-1:0]      amp_re_o,
  output logic signed [AMP_W-1:0]      amp_im_o,
  output logic [1:0]                   error_o
);

  function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] y;
    y = (x + SUM_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
    if (y > SUM_W'((1 << (AMP_W - 1)) - 1)) begin
      return AMP_W'((1 << (AMP_W - 1)) - 1);
    end else if (y < -SUM_W'(1 << (AMP_W - 1))) begin
      return AMP_W'(1 << (AMP_W - 1));
    end
    return y[AMP_W-1:0];
  endfunction

  function automatic logic [QUOT_W:0] amp_mag(input logic signed [AMP_W-1:0] a);
    logic signed [AMP_W:0] ax;
    ax = (AMP_W+1)'(a);
    return ax[AMP_W] ? (QUOT_W+1)'(-ax) : (QUOT_W+1)'(ax);
  endfunction

  function automatic logic signed [AMP_W-1:0] rn_final(input logic signed [AMP_W-1:0] a,
                                                       input logic sat,
                                                       input logic [QUOT_W-1:0] q);
    logic signed [QUOT_W+1:0] v;
    if (sat) begin
      return a[AMP_W-1] ? AMP_W'(1 << (AMP_W - 1)) : AMP_W'((1 << (AMP_W - 1)) - 1);
    end
    v = a[AMP_W-1] ? -(QUOT_W+2)'(q) : (QUOT_W+2)'(q);
    if (v > (QUOT_W+2)'((1 << (AMP_W - 1)) - 1)) begin
      return AMP_W'((1 << (AMP_W - 1)) - 1);
    end
    return v[AMP_W-1:0];
  endfunction

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [QB_W-1:0]             nq_q, nq_d;
  cmd_e                        cmd_q, cmd_d;
  logic [QB_W-1:0]             tq_q, tq_d;
  logic signed [AMP_W-1:0]     g_q [8];
  logic signed [AMP_W-1:0]     g_d [8];
  logic [RND_W-1:0]            rnd_q, rnd_d;
  logic                        clr_res_q, clr_res_d;
  logic signed [AMP_W-1:0]     a_re_q, a_re_d, a_im_q, a_im_d, b_re_q, b_re_d, b_im_q, b_im_d;
  logic signed [2*AMP_W-1:0]   prod_q [16];
  logic signed [2*AMP_W-1:0]   prod_d [16];
  logic signed [SUM_W-1:0]     sum_q [4];
  logic signed [SUM_W-1:0]     sum_d [4];
  logic [PROB_W-1:0]           p0_q, p0_d, p1_q, p1_d, tot_q, tot_d, kept_q, kept_d;
  logic [CMPV_W-1:0]           cmpv_q, cmpv_d;
  logic                        res_q, res_d;
  logic [SQRT_W-1:0]           sn_q, sn_d, sr_q, sr_d, sb_q, sb_d;
  logic [NUM_W-1:0]            lim_q, lim_d;
  logic                        v1_q, v1_d, b1_q, b1_d, v2_q, v2_d, b2_q, b2_d;
  logic [SQ_W-1:0]             sq2_q, sq2_d;
  logic                        r_out_q, r_out_d;
  logic signed [AMP_W-1:0]     r_re_q, r_re_d, r_im_q, r_im_d;
  logic [1:0]                  r_err_q, r_err_d;
  logic                        done_q, done_d;

  logic                        we;
  logic [ADDR_W-1:0]           waddr, raddr;
  logic [DATA_W-1:0]           wdata, rdata;
  logic signed [AMP_W-1:0]     rd_re, rd_im;

  logic [QB_W-1:0]             n_use;
  logic [CNT_W-1:0]            size;
  logic [ADDR_W-1:0]           bitm, lowm, pi, pj;
  logic [ROOT_W-1:0]           s_root;
  logic [NUM_W-1:0]            num_re, num_im;
  logic                        sat_re, sat_im, dv_start, dv_done_re, dv_done_im;
  logic [QUOT_W-1:0]           q_re, q_im;
  logic [SQRT_W-1:0]           s_try;
  logic signed [2*AMP_W-1:0]   sqr_re, sqr_im;

  svgm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_re  = rdata[DATA_W-1:AMP_W];
  assign rd_im  = rdata[AMP_W-1:0];
  assign s_root = sr_q[ROOT_W-1:0];
  assign num_re = (NUM_W'(amp_mag(a_re_q)) << RN_SHIFT) + NUM_W'(s_root >> 1);
  assign num_im = (NUM_W'(amp_mag(a_im_q)) << RN_SHIFT) + NUM_W'(s_root >> 1);
  assign sat_re = num_re >= lim_q;
  assign sat_im = num_im >= lim_q;

  svgm_div u_div_re (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (dv_start),
    .num_i (num_re), .den_i (s_root), .done_o (dv_done_re), .quot_o (q_re)
  );

  svgm_div u_div_im (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (dv_start),
    .num_i (num_im), .den_i (s_root), .done_o (dv_done_im), .quot_o (q_im)
  );

  always_comb begin
    if (nq_q == '0) begin
      n_use = QB_W'(1);
    end else if (nq_q > QB_W'(MAX_QUBITS)) begin
      n_use = QB_W'(MAX_QUBITS);
    end else begin
      n_use = nq_q;
    end
    size = CNT_W'(1) << n_use;
    bitm = ADDR_W'(1) << tq_q;
    lowm = bitm - 1'b1;
    pi   = ((cnt_q[ADDR_W-1:0] & ~lowm) << 1) | (cnt_q[ADDR_W-1:0] & lowm);
    pj   = pi | bitm;
    s_try  = sr_q + sb_q;
    sqr_re = (2*AMP_W)'(rd_re) * (2*AMP_W)'(rd_re);
    sqr_im = (2*AMP_W)'(rd_im) * (2*AMP_W)'(rd_im);
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nq_d      = nq_q;
    cmd_d     = cmd_q;
    tq_d      = tq_q;
    g_d       = g_q;
    rnd_d     = rnd_q;
    clr_res_d = clr_res_q;
    a_re_d    = a_re_q;
    a_im_d    = a_im_q;
    b_re_d    = b_re_q;
    b_im_d    = b_im_q;
    prod_d    = prod_q;
    sum_d     = sum_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    tot_d     = tot_q;
    kept_d    = kept_q;
    cmpv_d    = cmpv_q;
    res_d     = res_q;
    sn_d      = sn_q;
    sr_d      = sr_q;
    sb_d      = sb_q;
    lim_d     = lim_q;
    r_out_d   = r_out_q;
    r_re_d    = r_re_q;
    r_im_d    = r_im_q;
    r_err_d   = r_err_q;
    done_d    = 1'b0;
    dv_start  = 1'b0;
    we        = 1'b0;
    waddr     = cnt_q[ADDR_W-1:0];
    wdata     = '0;
    raddr     = cnt_q[ADDR_W-1:0];

    // probability pipeline: read data -> squares -> accumulate
    v1_d  = 1'b0;
    b1_d  = 1'b0;
    v2_d  = v1_q;
    b2_d  = b1_q;
    sq2_d = SQ_W'(sqr_re) + SQ_W'(sqr_im);
    if (v2_q) begin
      if (b2_q) begin
        p1_d = p1_q + PROB_W'(sq2_q);
      end else begin
        p0_d = p0_q + PROB_W'(sq2_q);
      end
    end

    if (cfg_valid_i) begin
      nq_d = cfg_data_i;
    end

    case (state_q)
      ST_CLR: begin
        we    = 1'b1;
        wdata = (cnt_q == '0) ? {AMP_ONE, AMP_W'(0)} : '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          state_d = clr_res_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(cmd_i);
          tq_d    = target_qubit_i;
          g_d[0]  = g00_re_i;
          g_d[1]  = g00_im_i;
          g_d[2]  = g01_re_i;
          g_d[3]  = g01_im_i;
          g_d[4]  = g10_re_i;
          g_d[5]  = g10_im_i;
          g_d[6]  = g11_re_i;
          g_d[7]  = g11_im_i;
          rnd_d   = random_fraction_i;
          cnt_d   = '0;
          p0_d    = '0;
          p1_d    = '0;
          r_out_d = 1'b0;
          r_re_d  = '0;
          r_im_d  = '0;
          r_err_d = ERR_NONE;
          raddr   = amp_index_i;
          case (cmd_e'(cmd_i))
            CMD_RESET: begin
              clr_res_d = 1'b1;
              state_d   = ST_CLR;
            end
            CMD_GATE: begin
              if (target_qubit_i >= n_use) begin
                r_err_d = ERR_RANGE;
                state_d = ST_FIN;
              end else begin
                state_d = ST_G_RA;
              end
            end
            CMD_MEASURE: begin
              if (target_qubit_i >= n_use) begin
                r_err_d = ERR_RANGE;
                state_d = ST_FIN;
              end else begin
                state_d = ST_M_SUM;
              end
            end
            default: begin
              if (CNT_W'(amp_index_i) >= size) begin
                r_err_d = ERR_RANGE;
                state_d = ST_FIN;
              end else begin
                state_d = ST_RD;
              end
            end
          endcase
        end
      end
      ST_RD: begin
        r_re_d  = rd_re;
        r_im_d  = rd_im;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_G_RA: begin
        raddr   = pi;
        state_d = ST_G_RB;
      end
      ST_G_RB: begin
        raddr   = pj;
        a_re_d  = rd_re;
        a_im_d  = rd_im;
        state_d = ST_G_CAP;
      end
      ST_G_CAP: begin
        b_re_d  = rd_re;
        b_im_d  = rd_im;
        state_d = ST_G_MUL;
      end
      ST_G_MUL: begin
        for (int r = 0; r < 2; r++) begin
          prod_d[8*r+0] = (2*AMP_W)'(g_q[4*r+0]) * (2*AMP_W)'(a_re_q);
          prod_d[8*r+1] = (2*AMP_W)'(g_q[4*r+1]) * (2*AMP_W)'(a_im_q);
          prod_d[8*r+2] = (2*AMP_W)'(g_q[4*r+2]) * (2*AMP_W)'(b_re_q);
          prod_d[8*r+3] = (2*AMP_W)'(g_q[4*r+3]) * (2*AMP_W)'(b_im_q);
          prod_d[8*r+4] = (2*AMP_W)'(g_q[4*r+0]) * (2*AMP_W)'(a_im_q);
          prod_d[8*r+5] = (2*AMP_W)'(g_q[4*r+1]) * (2*AMP_W)'(a_re_q);
          prod_d[8*r+6] = (2*AMP_W)'(g_q[4*r+2]) * (2*AMP_W)'(b_im_q);
          prod_d[8*r+7] = (2*AMP_W)'(g_q[4*r+3]) * (2*AMP_W)'(b_re_q);
        end
        state_d = ST_G_SUM;
      end
      ST_G_SUM: begin
        for (int r = 0; r < 2; r++) begin
          sum_d[2*r]   = SUM_W'(prod_q[8*r+0]) - SUM_W'(prod_q[8*r+1])
                       + SUM_W'(prod_q[8*r+2]) - SUM_W'(prod_q[8*r+3]);
          sum_d[2*r+1] = SUM_W'(prod_q[8*r+4]) + SUM_W'(prod_q[8*r+5])
                       + SUM_W'(prod_q[8*r+6]) + SUM_W'(prod_q[8*r+7]);
        end
        state_d = ST_G_WA;
      end
      ST_G_WA: begin
        we      = 1'b1;
        waddr   = pi;
        wdata   = {sat_amp(sum_q[0]), sat_amp(sum_q[1])};
        state_d = ST_G_WB;
      end
      ST_G_WB: begin
        we    = 1'b1;
        waddr = pj;
        wdata = {sat_amp(sum_q[2]), sat_amp(sum_q[3])};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == (size >> 1)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_G_RA;
        end
      end
      ST_M_SUM: begin
        v1_d  = 1'b1;
        b1_d  = (cnt_q[ADDR_W-1:0] & bitm) != '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == size) begin
          state_d = ST_M_DRN;
        end
      end
      ST_M_DRN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_M_TOT;
        end
      end
      ST_M_TOT: begin
        tot_d   = p0_q + p1_q;
        state_d = ST_M_MUL;
      end
      ST_M_MUL: begin
        cmpv_d  = CMPV_W'(rnd_q) * CMPV_W'(tot_q);
        state_d = ST_M_CMP;
      end
      ST_M_CMP: begin
        res_d  = !(cmpv_q < (CMPV_W'(p0_q) << RND_W));
        kept_d = (cmpv_q < (CMPV_W'(p0_q) << RND_W)) ? p0_q : p1_q;
        if (((cmpv_q < (CMPV_W'(p0_q) << RND_W)) ? p0_q : p1_q) == '0) begin
          r_err_d = ERR_ZERO;
          state_d = ST_FIN;
        end else begin
          sn_d    = SQRT_W'(((cmpv_q < (CMPV_W'(p0_q) << RND_W)) ? p0_q : p1_q)) << RND_W;
          sr_d    = '0;
          sb_d    = SQRT_W'(1) << (2 * (SQRT_STEPS - 1));
          cnt_d   = '0;
          state_d = ST_M_SQRT;
        end
      end
      ST_M_SQRT: begin
        if (sn_q >= s_try) begin
          sn_d = sn_q - s_try;
          sr_d = (sr_q >> 1) + sb_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sb_d  = sb_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = ST_M_LIM;
        end
      end
      ST_M_LIM: begin
        lim_d   = NUM_W'(s_root) * NUM_W'((1 << (AMP_W - 1)) + 1);
        cnt_d   = '0;
        state_d = ST_M_RD;
      end
      ST_M_RD: begin
        state_d = ST_M_LAT;
      end
      ST_M_LAT: begin
        a_re_d  = rd_re;
        a_im_d  = rd_im;
        state_d = ST_M_CHK;
      end
      ST_M_CHK: begin
        if (((cnt_q[ADDR_W-1:0] & bitm) != '0) != res_q) begin
          we    = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q + 1'b1 == size) begin
            r_out_d = res_q;
            state_d = ST_FIN;
          end else begin
            state_d = ST_M_RD;
          end
        end else begin
          dv_start = 1'b1;
          state_d  = ST_M_DIV;
        end
      end
      ST_M_DIV: begin
        if (dv_done_re && dv_done_im) begin
          state_d = ST_M_WR;
        end
      end
      ST_M_WR: begin
        we    = 1'b1;
        wdata = {rn_final(a_re_q, sat_re, q_re), rn_final(a_im_q, sat_im, q_im)};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == size) begin
          r_out_d = res_q;
          state_d = ST_FIN;
        end else begin
          state_d = ST_M_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      cnt_q     <= '0;
      nq_q      <= QB_W'(MAX_QUBITS);
      clr_res_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      nq_q      <= nq_d;
      clr_res_q <= clr_res_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    tq_q    <= tq_d;
    g_q     <= g_d;
    rnd_q   <= rnd_d;
    a_re_q  <= a_re_d;
    a_im_q  <= a_im_d;
    b_re_q  <= b_re_d;
    b_im_q  <= b_im_d;
    prod_q  <= prod_d;
    sum_q   <= sum_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    tot_q   <= tot_d;
    kept_q  <= kept_d;
    cmpv_q  <= cmpv_d;
    res_q   <= res_d;
    sn_q    <= sn_d;
    sr_q    <= sr_d;
    sb_q    <= sb_d;
    lim_q   <= lim_d;
    b1_q    <= b1_d;
    b2_q    <= b2_d;
    sq2_q   <= sq2_d;
    r_out_q <= r_out_d;
    r_re_q  <= r_re_d;
    r_im_q  <= r_im_d;
    r_err_q <= r_err_d;
  end

  // result registers load on the finish step
  logic                    o_out_q;
  logic signed [AMP_W-1:0] o_re_q, o_im_q;
  logic [1:0]              o_err_q;

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      o_out_q <= r_out_q;
      o_re_q  <= r_re_q;
      o_im_q  <= r_im_q;
      o_err_q <= r_err_q;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign outcome_o   = o_out_q;
  assign amp_re_o    = o_re_q;
  assign amp_im_o    = o_im_q;
  assign error_o     = (cmd_q == CMD_READ || kept_q != '0) ? o_err_q : o_err_q;

endmodule

`default_nettype wire

// File: sv/svgm_ram.sv
// ----------------------------------------------------------------------------
// svgm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module svgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/svgm_div.sv
// ----------------------------------------------------------------------------
// svgm_div
// Restoring divider, one quotient bit per cycle; quotient must fit QUOT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module svgm_div
  import svgm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [ROOT_W-1:0] den_i,
  output logic                   done_o,
  output logic [QUOT_W-1:0]      quot_o
);

  logic [NUM_W-1:0]          rem_q, rem_d, dv_q, dv_d;
  logic [QUOT_W-1:0]         quo_q, quo_d;
  logic [$clog2(QUOT_W)-1:0] step_q, step_d;
  logic                      act_q, act_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    step_d = step_q;
    act_d  = act_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dv_d   = NUM_W'(den_i) << (QUOT_W - 1);
      quo_d  = '0;
      step_d = '0;
      act_d  = 1'b1;
    end else if (act_q) begin
      if (rem_q >= dv_q) begin
        rem_d = rem_q - dv_q;
        quo_d = {quo_q[QUOT_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QUOT_W-2:0], 1'b0};
      end
      dv_d   = dv_q >> 1;
      step_d = step_q + 1'b1;
      if (step_q == ($clog2(QUOT_W))'(QUOT_W - 1)) begin
        act_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      act_q  <= act_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// File: sv/svgm_checker.sv
// ----------------------------------------------------------------------------
// svgm_checker
// Port-level checks on the state vector engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module svgm_checker
  import svgm_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    done_o,
  input wire logic                    outcome_o,
  input wire logic signed [AMP_W-1:0] amp_re_o,
  input wire logic signed [AMP_W-1:0] amp_im_o,
  input wire logic [1:0]              error_o
);

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request taken without going busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while still busy");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && error_o != ERR_NONE |-> !outcome_o && amp_re_o == '0 && amp_im_o == '0)
    else $error("error result carries data");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> error_o == ERR_NONE || error_o == ERR_RANGE || error_o == ERR_ZERO)
    else $error("undefined error code");

endmodule

bind state_vector_gate_measure svgm_checker u_svgm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .outcome_o (outcome_o),
  .amp_re_o  (amp_re_o),
  .amp_im_o  (amp_im_o),
  .error_o   (error_o)
);

`default_nettype wire
